// ----- sv/swfp_pkg.sv -----
// ----------------------------------------------------------------------------
// swfp_pkg: shared types and constants for the movie-file tag parser
// Tag category table and status codes.
// ----------------------------------------------------------------------------
package swfp_pkg;

    localparam int CountWidthDef = 32;
    localparam int NumCat        = 20;
    localparam int CatW          = 5;
    localparam int TagW          = 10;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SMALL   = 3'd1;
    localparam logic [2:0] ST_NOTSWF  = 3'd2;
    localparam logic [2:0] ST_ZLIB    = 3'd3;
    localparam logic [2:0] ST_LZMA    = 3'd4;
    localparam logic [2:0] ST_TRUNC   = 3'd5;

    localparam logic [TagW-1:0] TagFileAttr = TagW'(69);
    localparam logic [TagW-1:0] TagEnd      = TagW'(0);

    typedef struct packed {
        logic            hit;
        logic [CatW-1:0] cat;
    } t_cat;

    function automatic t_cat category_of(input logic [TagW-1:0] t);
        t_cat r;
        r.hit = 1'b1;
        r.cat = '0;
        case (t)
            10'd12: r.cat = 5'd0;
            10'd59: r.cat = 5'd1;
            10'd82: r.cat = 5'd2;
            10'd69: r.cat = 5'd3;
            10'd76: r.cat = 5'd4;
            10'd56: r.cat = 5'd5;
            10'd57, 10'd71: r.cat = 5'd6;
            10'd39: r.cat = 5'd7;
            10'd2, 10'd22, 10'd32, 10'd83: r.cat = 5'd8;
            10'd46, 10'd84: r.cat = 5'd9;
            10'd6, 10'd20, 10'd21, 10'd35, 10'd36, 10'd90: r.cat = 5'd10;
            10'd10, 10'd48, 10'd73, 10'd75, 10'd88, 10'd91: r.cat = 5'd11;
            10'd11, 10'd33: r.cat = 5'd12;
            10'd37: r.cat = 5'd13;
            10'd7, 10'd34: r.cat = 5'd14;
            10'd14, 10'd15, 10'd17, 10'd18, 10'd19, 10'd45, 10'd89: r.cat = 5'd15;
            10'd60, 10'd61: r.cat = 5'd16;
            10'd78: r.cat = 5'd17;
            10'd87: r.cat = 5'd18;
            10'd24, 10'd58, 10'd63, 10'd64, 10'd65, 10'd66, 10'd74, 10'd77,
            10'd86: r.cat = 5'd19;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/swfp_ram.sv -----
// ----------------------------------------------------------------------------
// swfp_ram: generic single-port-write, single-read RAM
// Registered read: data appears in the cycle after the address.
// ----------------------------------------------------------------------------
module swfp_ram #(
    parameter int Width = 32,
    parameter int Depth = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- sv/swf_tag_stream_parser_unit.sv -----
// ----------------------------------------------------------------------------
// swf_tag_stream_parser_unit: movie-file header and tag walker
// Parses one byte per request, counts tags per category in a RAM.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                   | tuser | tlast
// s_axis  | in  | file_byte[7:0]                          | -     | end_of_file
// m_axis  | out | status..tally (see port comment)        | kind  | final_item
//
// One byte per cycle while parsing. A completed tag does a read-modify-write
// of its category counter in the next cycle; the byte after a completed tag is
// always a tag header byte or a byte after the end tag, so the interlock never
// has to stall it. On end of file: a summary request once any pending counter
// update has landed, then each count request after a RAM read, then a clearing
// sweep of the counter RAM; input is held off throughout, and during the
// clearing sweep after reset. Output holds under m_axis_tready low.
module swf_tag_stream_parser_unit #(
    parameter int CountWidth = swfp_pkg::CountWidthDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // file_byte
    input  logic         s_axis_tlast,   // end_of_file
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0] format_version[10:3] declared_size[42:11] received_size[74:43]
    // size_mismatch[75] frames_per_second[83:76] frame_total[99:84]
    // as3_marked[100] category_index[105:101] tally[137:106], zero in [143:138]
    output logic [143:0] m_axis_tdata,
    output logic         m_axis_tuser,   // report_kind
    output logic         m_axis_tlast    // final_item
);
    import swfp_pkg::*;

    localparam logic [CountWidth-1:0] CntMax = '1;

    typedef enum logic [3:0] {
        PH_HDR, PH_RECT0, PH_RECTS, PH_MOV0, PH_MOV1, PH_MOV2, PH_MOV3,
        PH_TH0, PH_TH1, PH_L0, PH_L1, PH_L2, PH_L3, PH_BODY, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {M_RUN, M_SUM, M_CNT, M_CLR} t_mode;

    t_mode            r_mode;
    t_phase           r_ph, n_ph;
    logic [31:0]      r_pos, n_pos;
    logic [2:0]       r_hst, n_hst;
    logic [7:0]       r_ver, n_ver;
    logic [31:0]      r_decl, n_decl;
    logic [4:0]       r_rect, n_rect;
    logic [7:0]       r_rate, n_rate;
    logic [15:0]      r_frm, n_frm;
    logic [7:0]       r_hw, n_hw;
    logic [31:0]      r_lg, n_lg;
    logic [31:0]      r_left, n_left;
    logic [TagW-1:0]  r_tag, n_tag;
    logic             r_pas3, n_pas3;
    logic             r_as3, n_as3;
    logic [CountWidth-1:0] r_tot, n_tot;
    logic             n_fin;
    logic [CatW-1:0]  r_idx;

    // pending counter update: read issued, write next cycle
    logic             r_upd;
    logic [CatW-1:0]  r_ucat;
    logic             r_out_pend; // report requested; RAM read issued for r_idx

    logic                  ram_we;
    logic [CatW-1:0]       ram_wa, ram_ra;
    logic [CountWidth-1:0] ram_wd, ram_rd;

    swfp_ram #(.Width(CountWidth), .Depth(NumCat)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(ram_wd),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    logic acc;
    t_cat fc;
    // category of the tag that this byte may finish
    assign fc = category_of(n_tag);

    // next-state of parser for the current byte
    always_comb begin
        logic [7:0] b;
        logic [15:0] w;
        logic [31:0] len;
        logic [4:0] nr;
        logic bb;
        b = s_axis_tdata;
        w = '0; len = '0; nr = '0; bb = 1'b0;
        n_ph = r_ph; n_pos = (r_pos != 32'hFFFF_FFFF) ? r_pos + 32'd1 : r_pos;
        n_hst = r_hst; n_ver = r_ver; n_decl = r_decl; n_rect = r_rect;
        n_rate = r_rate; n_frm = r_frm; n_hw = r_hw; n_lg = r_lg;
        n_left = r_left; n_tag = r_tag; n_pas3 = r_pas3; n_as3 = r_as3;
        n_tot = r_tot; n_fin = 1'b0;
        case (r_ph)
            PH_HDR: begin
                if (r_pos == 32'd0)
                    n_hst = (b == 8'h46) ? ST_OK : (b == 8'h43) ? ST_ZLIB :
                            (b == 8'h5A) ? ST_LZMA : ST_NOTSWF;
                else if (r_pos == 32'd1) begin
                    if (b != 8'h57) n_hst = ST_NOTSWF;
                end else if (r_pos == 32'd2) begin
                    if (b != 8'h53) n_hst = ST_NOTSWF;
                end else if (r_pos == 32'd3) n_ver = b;
                else if (r_pos < 32'd8)
                    n_decl = r_decl | ({24'd0, b} << {r_pos[1:0], 3'd0});
                if (r_pos >= 32'd7) n_ph = (n_hst == ST_OK) ? PH_RECT0 : PH_DONE;
            end
            PH_RECT0: begin
                nr = 5'((8'd12 + {1'b0, b[7:3], 2'b00}) >> 3);
                if (nr > 5'd1) begin n_rect = nr - 5'd1; n_ph = PH_RECTS; end
                else n_ph = PH_MOV0;
            end
            PH_RECTS: begin
                if (r_rect > 5'd0) n_rect = r_rect - 5'd1;
                if (n_rect == 5'd0) n_ph = PH_MOV0;
            end
            PH_MOV0: n_ph = PH_MOV1;
            PH_MOV1: begin n_rate = b; n_ph = PH_MOV2; end
            PH_MOV2: begin n_frm = {8'd0, b}; n_ph = PH_MOV3; end
            PH_MOV3: begin n_frm = {b, r_frm[7:0]}; n_ph = PH_TH0; end
            PH_TH0: begin n_hw = b; n_ph = PH_TH1; end
            PH_TH1: begin
                w = {b, r_hw};
                n_tag = w[15:6];
                if (w[5:0] == 6'h3F) begin n_lg = '0; n_ph = PH_L0; end
                else begin len = {26'd0, w[5:0]}; bb = 1'b1; end
            end
            PH_L0: begin n_lg = {24'd0, b}; n_ph = PH_L1; end
            PH_L1: begin n_lg = {16'd0, b, r_lg[7:0]}; n_ph = PH_L2; end
            PH_L2: begin n_lg = {8'd0, b, r_lg[15:0]}; n_ph = PH_L3; end
            PH_L3: begin len = {b, r_lg[23:0]}; bb = 1'b1; end
            PH_BODY: begin
                if (r_left == r_lg && r_tag == TagFileAttr && r_lg >= 32'd4)
                    n_pas3 = b[3];
                if (r_left > 32'd0) n_left = r_left - 32'd1;
                if (n_left == 32'd0) n_fin = 1'b1;
            end
            default: ;
        endcase
        if (bb) begin
            n_lg = len; n_left = len; n_pas3 = 1'b0;
            if (len == 32'd0) n_fin = 1'b1; else n_ph = PH_BODY;
        end
        if (n_fin) begin
            if (r_tot != CntMax) n_tot = r_tot + 1'b1;
            if (n_pas3) n_as3 = 1'b1;
            n_pas3 = 1'b0;
            n_ph = (n_tag == TagEnd) ? PH_DONE : PH_TH0;
        end
    end

    // stall a byte that would finish a tag while an update is in flight
    logic fin_possible;
    assign fin_possible = (r_ph == PH_BODY) || (r_ph == PH_TH1) || (r_ph == PH_L3);
    assign s_axis_tready = (r_mode == M_RUN) && !(r_upd && fin_possible);
    assign acc = s_axis_tvalid && s_axis_tready;

    // report fields latched at end of file
    logic [2:0]  r_st;
    logic [31:0] r_rpos, r_odecl;
    logic [7:0]  r_over, r_orate;
    logic [15:0] r_ofrm;
    logic        r_omis, r_oas3;
    logic [CountWidth-1:0] r_otot;

    logic out_take;
    assign out_take = m_axis_tvalid && m_axis_tready;

    assign ram_ra = (r_mode == M_RUN) ? fc.cat : r_idx;
    always_comb begin
        ram_we = 1'b0; ram_wa = r_ucat; ram_wd = '0;
        if (r_mode == M_CLR) begin
            ram_we = 1'b1; ram_wa = r_idx;
        end else if (r_upd) begin
            ram_we = 1'b1;
            ram_wd = (ram_rd != CntMax) ? ram_rd + 1'b1 : ram_rd;
        end
    end

    logic [CountWidth-1:0] r_ocnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_CLR; r_idx <= '0; r_upd <= 1'b0; r_out_pend <= 1'b0;
            m_axis_tvalid <= 1'b0;
            r_ph <= PH_HDR; r_pos <= '0; r_hst <= '0; r_ver <= '0; r_decl <= '0;
            r_rect <= '0; r_rate <= '0; r_frm <= '0; r_hw <= '0; r_lg <= '0;
            r_left <= '0; r_tag <= '0; r_pas3 <= 1'b0; r_as3 <= 1'b0; r_tot <= '0;
        end else begin
            r_upd <= acc && n_fin && fc.hit;
            case (r_mode)
                M_RUN: begin
                    if (acc) begin
                        r_ph <= n_ph; r_pos <= n_pos; r_hst <= n_hst; r_ver <= n_ver;
                        r_decl <= n_decl; r_rect <= n_rect; r_rate <= n_rate;
                        r_frm <= n_frm; r_hw <= n_hw; r_lg <= n_lg; r_left <= n_left;
                        r_tag <= n_tag; r_pas3 <= n_pas3; r_as3 <= n_as3;
                        r_tot <= n_tot;
                        r_ucat <= fc.cat;
                        if (s_axis_tlast) begin
                            r_mode <= M_SUM;
                            r_idx  <= '0;
                            if (n_pos < 32'd8) r_st <= ST_SMALL;
                            else if (n_hst != ST_OK) r_st <= n_hst;
                            else if (n_ph != PH_HDR && n_ph != PH_TH0 &&
                                     n_ph != PH_TH1 && n_ph != PH_DONE)
                                r_st <= ST_TRUNC;
                            else r_st <= ST_OK;
                            r_rpos <= n_pos; r_otot <= n_tot; r_oas3 <= n_as3;
                            r_orate <= n_rate; r_ofrm <= n_frm;
                            r_over <= (n_pos < 32'd8 || n_hst == ST_NOTSWF) ? 8'd0 : n_ver;
                            r_odecl <= (n_pos < 32'd8 || n_hst == ST_NOTSWF) ? 32'd0
                                                                              : n_decl;
                            r_omis <= (n_pos >= 32'd8 && n_hst == ST_OK &&
                                       n_decl != n_pos);
                        end
                    end
                end
                M_SUM: begin
                    // wait for a pending update to land before reading counts
                    if (!r_upd) begin
                        if (!m_axis_tvalid) begin
                            m_axis_tvalid <= 1'b1;
                            m_axis_tuser <= 1'b0; m_axis_tlast <= 1'b0;
                            r_out_pend <= 1'b0;
                        end else if (out_take) begin
                            m_axis_tvalid <= 1'b0; r_mode <= M_CNT;
                        end
                    end
                end
                M_CNT: begin
                    // read address r_idx was presented last cycle
                    if (!m_axis_tvalid) begin
                        if (r_out_pend) begin
                            r_ocnt <= ram_rd; m_axis_tvalid <= 1'b1;
                            m_axis_tuser <= 1'b1;
                            m_axis_tlast <= (r_idx == CatW'(NumCat - 1));
                            r_out_pend <= 1'b0;
                        end else r_out_pend <= 1'b1;
                    end else if (out_take) begin
                        m_axis_tvalid <= 1'b0;
                        if (r_idx == CatW'(NumCat - 1)) begin
                            r_mode <= M_CLR; r_idx <= '0;
                        end else r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                    if (r_idx == CatW'(NumCat - 1)) begin
                        r_mode <= M_RUN;
                        r_ph <= PH_HDR; r_pos <= '0; r_hst <= '0; r_ver <= '0;
                        r_decl <= '0; r_rect <= '0; r_rate <= '0; r_frm <= '0;
                        r_hw <= '0; r_lg <= '0; r_left <= '0; r_tag <= '0;
                        r_pas3 <= 1'b0; r_as3 <= 1'b0; r_tot <= '0;
                    end else r_idx <= r_idx + 1'b1;
                end
            endcase
        end
    end

    logic kind;
    assign kind = m_axis_tuser;
    assign m_axis_tdata = kind ?
        {6'd0, 32'(r_ocnt), r_idx, 101'd0} :
        {6'd0, 32'(r_otot), 5'd0, r_oas3, r_ofrm, r_orate, r_omis, r_rpos,
         r_odecl, r_over, r_st};
endmodule

// ----- sv/swfp_checker.sv -----
// ----------------------------------------------------------------------------
// swfp_checker: port-level checks for the tag parser
// Report sequencing as seen on the streaming ports.
// ----------------------------------------------------------------------------
module swfp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata,
    input logic         m_axis_tuser,
    input logic         m_axis_tlast
);
    // no input while a report is out
    a_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken during report");
    // final item only on a count item of the last category
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
        (m_axis_tuser && m_axis_tdata[105:101] == 5'd19)) else $error("bad last");
    // summary item carries category zero
    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata[105:101] == 5'd0)
        else $error("summary category");
    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output not held");
endmodule

bind swf_tag_stream_parser_unit swfp_checker u_swfp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);

// ----- tb/sv/swf_tag_stream_parser_unit_chk.sv -----
// ----------------------------------------------------------------------------
// swf_tag_stream_parser_unit_chk: report checker for the movie-file parser
// Watches both streams, predicts the 21-item report of every file from the
// accepted bytes and compares each report request field by field.
// ----------------------------------------------------------------------------
module swf_tag_stream_parser_unit_chk (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [7:0]   i_in_byte,
    input  logic         i_in_last,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [143:0] i_out_data,
    input  logic         i_out_kind,
    input  logic         i_out_last,
    output int           o_errors,
    output int           o_pending,
    output int           o_reports
);
    import swfp_pkg::*;

    typedef enum logic [3:0] {
        P_HDR, P_RECT0, P_RECTS, P_MOV0, P_MOV1, P_MOV2, P_MOV3,
        P_TH0, P_TH1, P_L0, P_L1, P_L2, P_L3, P_BODY, P_DONE
    } t_phase;

    typedef struct packed {
        logic [143:0] data;
        logic         kind;
        logic         last;
    } t_report;

    t_phase      phase;
    logic [31:0] posn;
    logic [2:0]  hdr_st;
    logic [7:0]  ver;
    logic [31:0] decl;
    logic [4:0]  rect_left;
    logic [7:0]  rate;
    logic [15:0] frames;
    logic [15:0] hword;
    logic [31:0] len_acc;
    logic [31:0] body_left;
    logic [9:0]  tag;
    logic        as3_pend;
    logic        as3;
    logic [31:0] tag_cnt;
    logic [31:0] cat_cnt [NumCat];
    t_report     report_q [$];

    function automatic int tag_group(input logic [9:0] t);
        case (t)
            12: return 0;
            59: return 1;
            82: return 2;
            69: return 3;
            76: return 4;
            56: return 5;
            57, 71: return 6;
            39: return 7;
            2, 22, 32, 83: return 8;
            46, 84: return 9;
            6, 20, 21, 35, 36, 90: return 10;
            10, 48, 73, 75, 88, 91: return 11;
            11, 33: return 12;
            37: return 13;
            7, 34: return 14;
            14, 15, 17, 18, 19, 45, 89: return 15;
            60, 61: return 16;
            78: return 17;
            87: return 18;
            24, 58, 63, 64, 65, 66, 74, 77, 86: return 19;
            default: return -1;
        endcase
    endfunction

    task automatic clear_file();
        phase = P_HDR; posn = '0; hdr_st = ST_OK; ver = '0; decl = '0;
        rect_left = '0; rate = '0; frames = '0; hword = '0; len_acc = '0;
        body_left = '0; tag = '0; as3_pend = 1'b0; as3 = 1'b0; tag_cnt = '0;
        for (int k = 0; k < NumCat; k++) cat_cnt[k] = '0;
    endtask

    task automatic close_tag();
        int g;
        g = tag_group(tag);
        if (tag_cnt != '1) tag_cnt++;
        if (g >= 0 && cat_cnt[g] != '1) cat_cnt[g]++;
        if (as3_pend) as3 = 1'b1;
        as3_pend = 1'b0;
        phase = (tag == TagEnd) ? P_DONE : P_TH0;
    endtask

    task automatic open_body(input logic [31:0] n);
        len_acc = n;
        body_left = n;
        as3_pend = 1'b0;
        if (n == 0) close_tag();
        else phase = P_BODY;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic eof);
        logic [31:0] pos;
        int          n;
        logic        trunc;
        logic [2:0]  st;
        t_report     r;
        pos = posn;
        if (posn != '1) posn++;
        case (phase)
            P_HDR: begin
                if (pos == 0)
                    hdr_st = (b == 8'h46) ? ST_OK : (b == 8'h43) ? ST_ZLIB :
                             (b == 8'h5A) ? ST_LZMA : ST_NOTSWF;
                else if (pos == 1) begin
                    if (b != 8'h57) hdr_st = ST_NOTSWF;
                end else if (pos == 2) begin
                    if (b != 8'h53) hdr_st = ST_NOTSWF;
                end else if (pos == 3) ver = b;
                else if (pos < 8) decl[8*(pos-4) +: 8] = b;
                if (pos >= 7) phase = (hdr_st == ST_OK) ? P_RECT0 : P_DONE;
            end
            P_RECT0: begin
                n = (12 + 4 * int'(b[7:3])) / 8;
                if (n > 1) begin
                    rect_left = 5'(n - 1);
                    phase = P_RECTS;
                end else phase = P_MOV0;
            end
            P_RECTS: begin
                if (rect_left > 0) rect_left--;
                if (rect_left == 0) phase = P_MOV0;
            end
            P_MOV0: phase = P_MOV1;
            P_MOV1: begin rate = b; phase = P_MOV2; end
            P_MOV2: begin frames[7:0] = b; frames[15:8] = '0; phase = P_MOV3; end
            P_MOV3: begin frames[15:8] = b; phase = P_TH0; end
            P_TH0: begin hword = {8'h00, b}; phase = P_TH1; end
            P_TH1: begin
                hword[15:8] = b;
                tag = hword[15:6];
                if (hword[5:0] == 6'h3f) begin
                    len_acc = '0;
                    phase = P_L0;
                end else open_body({26'b0, hword[5:0]});
            end
            P_L0: begin len_acc[7:0] = b; phase = P_L1; end
            P_L1: begin len_acc[15:8] = b; phase = P_L2; end
            P_L2: begin len_acc[23:16] = b; phase = P_L3; end
            P_L3: open_body({b, len_acc[23:0]});
            P_BODY: begin
                if (body_left == len_acc && tag == TagFileAttr && len_acc >= 4)
                    as3_pend = b[3];
                if (body_left > 0) body_left--;
                if (body_left == 0) close_tag();
            end
            default: ;
        endcase
        if (!eof) return;

        trunc = phase inside {P_RECT0, P_RECTS, P_MOV0, P_MOV1, P_MOV2, P_MOV3,
                              P_L0, P_L1, P_L2, P_L3, P_BODY};
        if (posn < 8) st = ST_SMALL;
        else if (hdr_st != ST_OK) st = hdr_st;
        else st = trunc ? ST_TRUNC : ST_OK;

        r.kind = 1'b0;
        r.last = 1'b0;
        r.data = '0;
        r.data[2:0] = st;
        if (st != ST_SMALL && st != ST_NOTSWF) begin
            r.data[10:3]  = ver;
            r.data[42:11] = decl;
        end
        r.data[74:43]   = posn;
        r.data[75]      = (st == ST_OK || st == ST_TRUNC) && decl != posn;
        r.data[83:76]   = rate;
        r.data[99:84]   = frames;
        r.data[100]     = as3;
        r.data[137:106] = tag_cnt;
        report_q.insert(report_q.size(), r);
        for (int k = 0; k < NumCat; k++) begin
            r.kind = 1'b1;
            r.last = (k == NumCat - 1);
            r.data = '0;
            r.data[105:101] = 5'(k);
            r.data[137:106] = cat_cnt[k];
            report_q.insert(report_q.size(), r);
        end
        clear_file();
    endtask

    assign o_pending = report_q.size();

    always @(posedge i_clk) begin
        t_report want;
        if (!i_rst_n) begin
            clear_file();
            report_q.delete();
            o_errors  <= 0;
            o_reports <= 0;
        end else begin
            if (i_in_valid && i_in_ready) take_byte(i_in_byte, i_in_last);
            if (i_out_valid && i_out_ready) begin
                o_reports <= o_reports + 1;
                if (report_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("ERROR: unexpected report request kind=%0d data=%h",
                                 i_out_kind, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = report_q.pop_front();
                    if (want.data !== i_out_data || want.kind !== i_out_kind ||
                        want.last !== i_out_last) begin
                        if (o_errors < 10) begin
                            $display("ERROR: report mismatch kind exp %0d got %0d, last exp %0d got %0d",
                                     want.kind, i_out_kind, want.last, i_out_last);
                            $display("  st %0d/%0d ver %h/%h decl %h/%h recv %h/%h mis %0d/%0d",
                                     want.data[2:0], i_out_data[2:0],
                                     want.data[10:3], i_out_data[10:3],
                                     want.data[42:11], i_out_data[42:11],
                                     want.data[74:43], i_out_data[74:43],
                                     want.data[75], i_out_data[75]);
                            $display("  fps %h/%h frames %h/%h as3 %0d/%0d cat %0d/%0d tally %h/%h",
                                     want.data[83:76], i_out_data[83:76],
                                     want.data[99:84], i_out_data[99:84],
                                     want.data[100], i_out_data[100],
                                     want.data[105:101], i_out_data[105:101],
                                     want.data[137:106], i_out_data[137:106]);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/sv/swf_tag_stream_parser_unit_tb.sv -----
// ----------------------------------------------------------------------------
// swf_tag_stream_parser_unit_tb: stimulus and verdict for the tag parser
// Streams directed and random movie files byte by byte with random gaps and
// output stalls; the checker predicts and compares every report.
// ----------------------------------------------------------------------------
module swf_tag_stream_parser_unit_tb;
    import swfp_pkg::*;

    localparam int CycleLimit = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    int errors, pending, reports;
    int cycles = 0;
    int bytes_sent = 0;
    int files_sent = 0;
    logic quiet = 1'b1;
    logic [7:0] movie [$];

    // tag types worth hitting: every category, end tag, unknown ones
    int tag_pool [] = '{0, 12, 59, 82, 69, 69, 69, 76, 56, 57, 71, 39, 2, 83, 46, 84, 6,
                        90, 10, 91, 11, 33, 37, 7, 34, 14, 89, 60, 61, 78, 87, 24,
                        86, 1, 5, 1023};

    always #1 i_clk = ~i_clk;

    swf_tag_stream_parser_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    swf_tag_stream_parser_unit_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_byte(s_axis_tdata), .i_in_last(s_axis_tlast),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_kind(m_axis_tuser),
        .i_out_last(m_axis_tlast),
        .o_errors(errors), .o_pending(pending), .o_reports(reports)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 30);
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_movie();
        for (int k = 0; k < movie.size(); k++) begin
            while (!quiet && $urandom_range(0, 99) < 30) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= movie[k];
            s_axis_tlast  <= (k == movie.size() - 1);
            do @(posedge i_clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;
        // the block is busy with its report here anyway
        @(posedge i_clk);
        bytes_sent += movie.size();
        files_sent++;
    endtask

    task automatic append_byte(input logic [7:0] v);
        movie.insert(movie.size(), v);
    endtask

    // FWS header, minimal rectangle, rate and frame count
    task automatic start_movie(input logic [7:0] v);
        movie = '{8'h46, 8'h57, 8'h53, v, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h18, 8'h34, 8'h12};
    endtask

    task automatic put_tag(input logic [9:0] t, input int unsigned n, input logic wide);
        logic [15:0] hw;
        hw = {t, wide ? 6'h3f : 6'(n)};
        append_byte(hw[7:0]);
        append_byte(hw[15:8]);
        if (wide) for (int k = 0; k < 4; k++) append_byte(8'(n >> (8 * k)));
    endtask

    task automatic set_declared(input int unsigned n);
        if (movie.size() >= 8)
            for (int k = 0; k < 4; k++) movie[4 + k] = 8'(n >> (8 * k));
    endtask

    task automatic random_movie();
        int unsigned nb, n, ntag, len;
        logic [9:0]  t;
        logic        wide;
        if ($urandom_range(0, 9) == 0) begin
            movie.delete();
            n = $urandom_range(1, 20);
            repeat (n) append_byte(8'($urandom));
            if ($urandom_range(0, 1)) begin
                movie[0] = ($urandom_range(0, 1)) ? 8'h43 : 8'h5A;
                if (n > 2) begin movie[1] = 8'h57; movie[2] = 8'h53; end
            end
            return;
        end
        movie = '{8'h46, 8'h57, 8'h53, 8'($urandom), 8'h00, 8'h00, 8'h00, 8'h00};
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
        append_byte({5'(nb), 3'($urandom)});
        n = (12 + 4 * nb) / 8;
        repeat (n - 1 + 4) append_byte(8'($urandom));
        ntag = $urandom_range(0, 6);
        for (int i = 0; i < ntag; i++) begin
            t = ($urandom_range(0, 3) == 0) ? 10'($urandom) :
                10'(tag_pool[$urandom_range(0, tag_pool.size() - 1)]);
            if (t == TagEnd && $urandom_range(0, 1)) t = 10'd12;
            len  = $urandom_range(0, 6);
            wide = ($urandom_range(0, 4) == 0);
            put_tag(t, len, wide);
            repeat (len) append_byte(8'($urandom));
            if (t == TagEnd) break;
        end
        if ($urandom_range(0, 7) == 0) append_byte(8'($urandom));
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, movie.size());
            while (movie.size() > n) void'(movie.pop_back());
        end
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
        set_declared(($urandom_range(0, 3) == 0) ? $urandom : movie.size());
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // too small: one byte
        movie = '{8'h46};
        send_movie();
        // bad signature, remaining bytes only counted
        movie = '{8'h46, 8'h57, 8'h58, 8'h0a, 8'h0a, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00};
        send_movie();
        // zlib and lzma bodies
        movie = '{8'h43, 8'h57, 8'h53, 8'h0a, 8'hff, 8'hff, 8'hff, 8'hff, 8'h78, 8'h9c};
        send_movie();
        movie = '{8'h5A, 8'h57, 8'h53, 8'hff, 8'h09, 8'h00, 8'h00, 8'h00, 8'h5d};
        send_movie();
        // header only: truncated before the rectangle
        movie = '{8'h46, 8'h57, 8'h53, 8'h08, 8'h08, 8'h00, 8'h00, 8'h00};
        send_movie();
        // full file: FileAttributes with AS3, long-length tag, end tag, trailing byte
        start_movie(8'd10);
        put_tag(TagFileAttr, 4, 1'b0);
        append_byte(8'h08); repeat (3) append_byte(8'h00);
        put_tag(10'd82, 2, 1'b1);
        append_byte(8'hff); append_byte(8'h00);
        put_tag(10'd1023, 0, 1'b0);
        put_tag(TagEnd, 0, 1'b0);
        append_byte(8'hee);
        set_declared(movie.size());
        send_movie();
        // widest rectangle, short FileAttributes, half tag header at the end
        movie = '{8'h46, 8'h57, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff};
        repeat (16 + 4) append_byte(8'hff);
        put_tag(TagFileAttr, 3, 1'b0);
        repeat (3) append_byte(8'h08);
        append_byte(8'h40);
        set_declared(32'hffff_ffff);
        send_movie();
        // truncated inside a huge long-length body
        start_movie(8'hff);
        put_tag(10'd87, 32'hffff_ffff, 1'b1);
        append_byte(8'h55);
        send_movie();

        quiet = 1'b0;
        while (bytes_sent < 250) begin
            // one stretch with no gaps or stalls
            quiet = (bytes_sent >= 150 && bytes_sent < 200);
            random_movie();
            send_movie();
        end
        quiet = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("streamed %0d files, %0d bytes; checked %0d report requests",
                 files_sent, bytes_sent, reports);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d reports missing", errors, pending);
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ----- swf_tag_stream_parser_unit.f -----
sv/swfp_pkg.sv
sv/swfp_ram.sv
sv/swf_tag_stream_parser_unit.sv
sv/swfp_checker.sv
tb/sv/swf_tag_stream_parser_unit_chk.sv
tb/sv/swf_tag_stream_parser_unit_tb.sv
